// File: design/dmpsg_pkg.sv
`timescale 1ns / 1ps

package dmpsg_pkg;

   localparam int MaxSpeedDefault = 100;
   localparam int LaneCount       = 2;
   localparam int TickWidth       = 17;
   localparam int SpeedWidth      = 8;
   localparam int LevelWidth      = 4;

   localparam logic                  CmdSet    = 1'b0;
   localparam logic                  CmdTick   = 1'b1;
   localparam logic [LevelWidth-1:0] LevelStop = 4'd15;
   localparam logic [LevelWidth-1:0] GradeTop  = 4'd10;

   // What one motor lane reports for the request it has just taken.
   typedef struct packed {
      logic drive;
      logic backward;
      logic clamped;
   } lane_status_type;

   typedef struct packed {
      logic left_drive;
      logic right_drive;
      logic left_backward;
      logic right_backward;
      logic clamp_flag;
   } result_type;

   function automatic logic [TickWidth-1:0] on_len(input logic [LevelWidth-1:0] level);
      logic [TickWidth-1:0] len;
      case (level)
         4'd9:    len = 17'd4950;
         4'd10:   len = 17'd100000;
         default: len = 17'd50;
      endcase
      return len;
   endfunction

   function automatic logic [TickWidth-1:0] off_len(input logic [LevelWidth-1:0] level);
      logic [TickWidth-1:0] len;
      case (level)
         4'd0:    len = 17'd74950;
         4'd1:    len = 17'd54950;
         4'd2:    len = 17'd39950;
         4'd3:    len = 17'd29950;
         4'd4:    len = 17'd19950;
         4'd5:    len = 17'd14950;
         4'd6:    len = 17'd9950;
         4'd7:    len = 17'd4950;
         4'd8:    len = 17'd50;
         default: len = 17'd64;
      endcase
      return len;
   endfunction

   // Magnitude divided by ten, by the reciprocal 205/2048 (exact below 1024),
   // saturated at the top grade.
   function automatic logic [LevelWidth-1:0] grade_of(input logic [6:0] mag);
      logic [14:0] prod;
      logic [3:0]  quot;
      prod = 15'(mag) * 15'd205;
      quot = prod[14:11];
      return (quot > GradeTop) ? GradeTop : quot;
   endfunction

endpackage

// File: design/dmpsg_if.sv
`timescale 1ns / 1ps

interface dmpsg_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   logic signed [7:0] left_velocity;
   logic signed [7:0] right_velocity;

   modport source (output valid, output command, output left_velocity, output right_velocity,
                   input ready);
   modport sink   (input valid, input command, input left_velocity, input right_velocity,
                   output ready);
endinterface

interface dmpsg_rsp_if;
   logic valid;
   logic ready;
   logic left_drive;
   logic right_drive;
   logic left_backward;
   logic right_backward;
   logic clamp_flag;

   modport source (output valid, output left_drive, output right_drive,
                   output left_backward, output right_backward, output clamp_flag,
                   input ready);
   modport sink   (input valid, input left_drive, input right_drive,
                   input left_backward, input right_backward, input clamp_flag,
                   output ready);
endinterface

// File: design/dual_motor_pwm_speed_grade_core.sv
`timescale 1ns / 1ps

// Channel      Dir  Payload
// req_channel  in   command, left_velocity, right_velocity (signed 8-bit each)
// rsp_channel  out  left_drive, right_drive, left_backward, right_backward, clamp_flag
//
// Both motor lanes update their state at the accepting edge, so one request
// can be accepted every cycle while the result queue has room.
// Each result is queued at the accepting edge and waits behind any earlier result.
// A two-entry result queue lets a request be accepted while a result waits;
// ready drops only when both entries are full.
// Synchronous reset stops both motors, forward, off phase, tick count zero.

module dual_motor_pwm_speed_grade_core
   import dmpsg_pkg::*;
#(
   parameter int MAX_SPEED = MaxSpeedDefault
) (
   input  logic          clock,
   input  logic          reset,
   dmpsg_req_if.sink     req_channel,
   dmpsg_rsp_if.source   rsp_channel
);

   lane_status_type lane_status [LaneCount];
   logic signed [SpeedWidth-1:0] lane_speed [LaneCount];
   logic            fire;
   logic            space;
   result_type      result;

   // A request is taken whenever the result queue has room for its result.
   assign req_channel.ready = space;
   assign fire              = req_channel.valid & space;

   assign lane_speed[0] = req_channel.left_velocity;
   assign lane_speed[1] = req_channel.right_velocity;

   // One lane per motor; each carries its own phase counter and speed grade.
   for (genvar i = 0; i < LaneCount; i++) begin : g_lane
      dmpsg_motor_lane #(
         .MAX_SPEED (MAX_SPEED)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .fire    (fire),
         .command (req_channel.command),
         .speed   (lane_speed[i]),
         .status  (lane_status[i])
      );
   end

   // The merge stage joins both lanes into one result and queues it.
   dmpsg_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .left_status  (lane_status[0]),
      .right_status (lane_status[1]),
      .out_ready    (rsp_channel.ready),
      .out_valid    (rsp_channel.valid),
      .out_result   (result),
      .space        (space)
   );

   assign rsp_channel.left_drive     = result.left_drive;
   assign rsp_channel.right_drive    = result.right_drive;
   assign rsp_channel.left_backward  = result.left_backward;
   assign rsp_channel.right_backward = result.right_backward;
   assign rsp_channel.clamp_flag     = result.clamp_flag;

endmodule

// File: design/dmpsg_motor_lane.sv
`timescale 1ns / 1ps

module dmpsg_motor_lane
   import dmpsg_pkg::*;
#(
   parameter int MAX_SPEED = MaxSpeedDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  logic                         command,
   input  logic signed [SpeedWidth-1:0] speed,
   output lane_status_type              status
);

   localparam logic signed [SpeedWidth:0] MaxS = (SpeedWidth+1)'(MAX_SPEED);
   localparam logic signed [SpeedWidth:0] MinS = (SpeedWidth+1)'(-MAX_SPEED);

   logic                  phase_ff, phase_in;
   logic [TickWidth-1:0]  ticks_ff, ticks_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic                  dir_ff, dir_in;

   always_comb begin
      logic signed [SpeedWidth:0] speed_ext;
      logic signed [SpeedWidth:0] sat;
      logic [6:0]                 mag;
      logic [LevelWidth-1:0]      lvl;
      logic [TickWidth-1:0]       len;
      logic [TickWidth-1:0]       ticks_inc;
      logic                       clamped;

      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      level_in  = level_ff;
      dir_in    = dir_ff;
      clamped   = 1'b0;
      speed_ext = {speed[SpeedWidth-1], speed};
      sat       = speed_ext;
      if (speed_ext > MaxS) begin
         sat     = MaxS;
         clamped = 1'b1;
      end else if (speed_ext < MinS) begin
         sat     = MinS;
         clamped = 1'b1;
      end
      mag       = sat[SpeedWidth] ? 7'(-sat) : sat[6:0];
      lvl       = (mag == 7'd0) ? LevelStop : grade_of(mag);
      len       = phase_ff ? on_len(level_ff) : off_len(level_ff);
      ticks_inc = ticks_ff + 17'd1;

      status.drive    = 1'b0;
      status.clamped  = 1'b0;

      if (fire) begin
         if (command == CmdSet) begin
            status.clamped = clamped;
            dir_in         = sat[SpeedWidth];
            if (lvl != level_ff) begin
               level_in = lvl;
               ticks_in = '0;
               phase_in = (lvl != LevelStop);
            end
         end else if (level_ff > GradeTop) begin
            phase_in = 1'b0;
            ticks_in = '0;
         end else begin
            status.drive = phase_ff;
            if (ticks_inc >= len) begin
               phase_in = ~phase_ff;
               ticks_in = '0;
            end else begin
               ticks_in = ticks_inc;
            end
         end
      end
      status.backward = dir_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         ticks_ff <= '0;
         level_ff <= LevelStop;
         dir_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         ticks_ff <= ticks_in;
         level_ff <= level_in;
         dir_ff   <= dir_in;
      end
   end

endmodule

// File: design/dmpsg_merge.sv
`timescale 1ns / 1ps

module dmpsg_merge
   import dmpsg_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            fire,
   input  lane_status_type left_status,
   input  lane_status_type right_status,
   input  logic            out_ready,
   output logic            out_valid,
   output result_type      out_result,
   output logic            space
);

   // Two-entry result queue: head and one skid slot behind it.
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic [1:0] count_ff, count_in;
   result_type merged;
   logic       pop;

   always_comb begin
      merged.left_drive     = left_status.drive;
      merged.right_drive    = right_status.drive;
      merged.left_backward  = left_status.backward;
      merged.right_backward = right_status.backward;
      merged.clamp_flag     = left_status.clamped | right_status.clamped;
   end

   assign pop = out_valid & out_ready;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (fire) begin
               head_in  = merged;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (fire && pop) begin
               head_in = merged;
            end else if (pop) begin
               count_in = 2'd0;
            end else if (fire) begin
               skid_in  = merged;
               count_in = 2'd2;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = skid_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign out_valid  = (count_ff != 2'd0);
   assign out_result = head_ff;
   assign space      = (count_ff != 2'd2);

endmodule
